[rtl/assert_macros.svh]
// Assertion macros shared by checker files.
// Each takes a label, a clock, a property expression and a message; CHK_ASSERT also takes an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CHK_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

[rtl/ikr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the integer k-th root unit.
// No dependencies.
package ikr_pkg;
    localparam int WIDTH = 64;
    localparam int KW = 7;
    localparam int CW = $clog2(WIDTH + 1);

    typedef enum logic [5:0] {
        OP_NONE  = 6'b000001,
        OP_LOAD  = 6'b000010,
        OP_PINIT = 6'b000100,
        OP_PSTEP = 6'b001000,
        OP_DINIT = 6'b010000,
        OP_DSTEP = 6'b100000
    } t_op;

    typedef struct packed {
        t_op op;
        logic qsel;   // in DINIT: 0 = n/p, 1 = d/k; in PINIT: 1 = apply the step to x
    } t_cmd;

    typedef struct packed {
        logic trivial;   // result known at load
        logic pow_done;  // exponent exhausted or saturated
        logic pow_big;
        logic div_done;
        logic q_ge_x;    // q >= x after the n/p division, or x is zero
    } t_sts;
endpackage

[rtl/ikr_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interface for input and result beats.
// Depends on ikr_pkg.
interface ikr_in_if import ikr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] radicand;
    logic [KW-1:0]    root_order;
    modport source (output valid, radicand, root_order, input ready);
    modport sink (input valid, radicand, root_order, output ready);
endinterface

interface ikr_out_if import ikr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] root;
    modport source (output valid, root, input ready);
    modport sink (input valid, root, output ready);
endinterface

[rtl/integer_kth_root_unit.sv]
`timescale 1ns / 1ps
// Channel   | dir | beat payload
// s_in      | in  | radicand[63:0], root_order[6:0]
// m_out     | out | root[63:0]
// One item at a time. Each Newton round runs the serial power (k-1 shift-add
// multiplies, cut short once it saturates), n div x^(k-1) and the step division
// by k. Load and check come before the first round; the result beat comes last.
// Reset (synchronous, active low) returns the controller to idle.
// A stalled result holds in the output state until taken; no new beat meanwhile.
module integer_kth_root_unit import ikr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    ikr_in_if.sink    s_in,
    ikr_out_if.source m_out
);
    t_cmd w_cmd;
    t_sts w_sts;

    ikr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_in.valid), .o_in_ready(s_in.ready),
        .o_out_valid(m_out.valid), .i_out_ready(m_out.ready),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    ikr_datapath u_dp (
        .i_clk(i_clk), .i_cmd(w_cmd),
        .i_radicand(s_in.radicand), .i_root_order(s_in.root_order),
        .o_sts(w_sts), .o_root(m_out.root)
    );
endmodule

[rtl/ikr_datapath.sv]
`timescale 1ns / 1ps
// Datapath: x, saturated power by shift-add multiply, restoring divider.
// Depends on ikr_pkg.
module ikr_datapath import ikr_pkg::*; (
    input  logic             i_clk,
    input  t_cmd             i_cmd,
    input  logic [WIDTH-1:0] i_radicand,
    input  logic [KW-1:0]    i_root_order,
    output t_sts             o_sts,
    output logic [WIDTH-1:0] o_root
);
    logic [WIDTH-1:0] r_n, r_x, r_p, r_quo, r_rem, r_dvs, r_dvd, r_mc, r_acc;
    logic [KW-1:0]    r_k, r_e;
    logic [CW-1:0]    r_cnt;
    logic             r_big, r_mul, r_qsel, r_qge;
    logic [WIDTH+1:0] w_sum;
    logic [WIDTH:0]   w_rem2;
    logic [WIDTH-1:0] w_d, w_step;
    logic             w_sub;

    // serial multiply acc += x when multiplier bit set; bits scanned msb first
    assign w_sum  = {1'b0, r_acc, 1'b0} + (r_mc[WIDTH-1] ? {2'b00, r_x} : '0);
    assign w_rem2 = {r_rem, r_dvd[WIDTH-1]};
    assign w_sub  = (w_rem2 >= {1'b0, r_dvs});
    assign w_d    = r_x - r_quo;
    // ceil(d / k) straight from the finished divider
    assign w_step = r_dvd + ((r_rem != '0) ? WIDTH'(1) : '0);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_n <= i_radicand;
                r_x <= i_radicand;
                r_k <= i_root_order;
            end
            OP_PINIT: begin
                if (i_cmd.qsel) begin
                    r_x <= r_x - w_step;
                end
                r_p   <= WIDTH'(1);
                r_e   <= r_k - KW'(1);
                r_big <= 1'b0;
                r_mul <= 1'b0;
            end
            OP_PSTEP: begin
                if (!r_mul) begin
                    r_mc  <= r_p;
                    r_acc <= '0;
                    r_cnt <= CW'(WIDTH);
                    r_mul <= 1'b1;
                end else if (r_cnt != '0) begin
                    if (w_sum > {2'b00, r_n}) begin
                        r_big <= 1'b1;
                        r_mul <= 1'b0;
                    end else begin
                        r_acc <= w_sum[WIDTH-1:0];
                        r_mc  <= r_mc << 1;
                        r_cnt <= r_cnt - CW'(1);
                    end
                end else begin
                    r_p   <= r_acc;
                    r_e   <= r_e - KW'(1);
                    r_mul <= 1'b0;
                end
            end
            OP_DINIT: begin
                r_qsel <= i_cmd.qsel;
                r_rem  <= '0;
                r_cnt  <= CW'(WIDTH);
                if (i_cmd.qsel) begin
                    r_dvd <= w_d;
                    r_dvs <= {{(WIDTH-KW){1'b0}}, r_k};
                    r_qge <= 1'b0;
                end else begin
                    // big power means quotient zero
                    if (r_big) begin
                        r_dvd <= '0;
                        r_dvs <= WIDTH'(1);
                    end else begin
                        r_dvd <= r_n;
                        r_dvs <= r_p;
                    end
                    r_qge <= 1'b0;
                end
            end
            OP_DSTEP: begin
                if (r_cnt != '0) begin
                    r_rem <= w_sub ? w_rem2[WIDTH-1:0] - r_dvs : w_rem2[WIDTH-1:0];
                    r_dvd <= {r_dvd[WIDTH-2:0], w_sub};
                    r_cnt <= r_cnt - CW'(1);
                end else if (!r_qsel) begin
                    r_quo <= r_dvd;
                    r_qge <= (r_dvd >= r_x);
                end else begin
                    r_quo <= r_dvd;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_sts.trivial  = (r_n == '0) || (r_k <= KW'(1));
    assign o_sts.pow_done = r_big || (r_e == '0 && !r_mul);
    assign o_sts.pow_big  = r_big;
    assign o_sts.div_done = (r_cnt == '0);
    assign o_sts.q_ge_x   = r_qge || (r_x == '0);
    assign o_root = (r_n == '0) ? '0 : r_x;
endmodule

[rtl/ikr_ctrl.sv]
`timescale 1ns / 1ps
// Controller sequencing load, power, divide and step phases.
// Depends on ikr_pkg.
module ikr_ctrl import ikr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CHK  = 7'b0000010,
        S_POW  = 7'b0000100,
        S_DIVN = 7'b0001000,
        S_DIVK = 7'b0010000,
        S_NEXT = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_pend;  // flag for quotient of n by power ready to test; never set

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_cmd.qsel = 1'b0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.trivial) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.op = OP_PINIT;
                    n_state  = S_POW;
                end
            end
            S_POW: begin
                if (i_sts.q_ge_x && r_pend) begin
                    n_state = S_OUT;
                end else if (i_sts.pow_done) begin
                    o_cmd.op = OP_DINIT;
                    n_state  = S_DIVN;
                end else begin
                    o_cmd.op = OP_PSTEP;
                end
            end
            S_DIVN: begin
                o_cmd.op = OP_DSTEP;
                if (i_sts.div_done) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (i_sts.q_ge_x) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.op   = OP_DINIT;
                    o_cmd.qsel = 1'b1;
                    n_state    = S_DIVK;
                end
            end
            S_DIVK: begin
                o_cmd.op   = OP_DSTEP;
                o_cmd.qsel = 1'b1;
                if (i_sts.div_done) begin
                    o_cmd.op   = OP_PINIT;
                    n_state    = S_POW;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= 1'b0;
        end
    end
endmodule

[rtl/ikr_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the k-th root unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module ikr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);
    `CHK_ASSERT(a_no_overlap, i_clk, i_rst_n, i_out_valid |-> !i_in_ready, "input while busy")
    `CHK_ASSERT(a_accept_busy, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready, "beat twice")
    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> i_out_valid, "drop")
    `CHK_ASSERT_NR(a_rst, i_clk, !i_rst_n |=> !i_out_valid, "result after reset")
endmodule

bind integer_kth_root_unit ikr_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(s_in.valid), .i_in_ready(s_in.ready),
    .i_out_valid(m_out.valid), .i_out_ready(m_out.ready)
);
